/* rtl/core/svf_pkg.sv */
// svf_pkg: shared types, constants and helpers for the vowel finder core
// no dependencies; used by sukhotin_vowel_finder_core
package svf_pkg;

  localparam int NUM_SYMBOLS = 26;
  localparam int SYM_W       = 5;
  localparam int PC_DEPTH    = NUM_SYMBOLS * NUM_SYMBOLS;
  localparam int PC_AW       = 10;
  localparam int CNT_W       = 16;
  localparam int RS_W        = 18;
  localparam int SEEN_W      = 17;
  localparam int MAX_TEXT    = 65536;
  localparam int VOWEL_LIMIT = 26;
  localparam int MAXV_W      = 5;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [SYM_W-1:0] vowel;
    logic             found;
    logic             overflow;
    logic             final_res;
  } out_t;

  // pair counts are symmetric: keep one entry per unordered pair
  function automatic logic [PC_AW-1:0] pair_addr(input logic [SYM_W-1:0] a,
                                                 input logic [SYM_W-1:0] b);
    logic [SYM_W-1:0] lo;
    logic [SYM_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return PC_AW'(PC_AW'(lo) * PC_AW'(NUM_SYMBOLS)) + PC_AW'(hi);
  endfunction

endpackage

/* rtl/core/sukhotin_vowel_finder_core.sv */
// sukhotin_vowel_finder_core: adjacency counting and vowel selection
// depends on svf_pkg
//
// Takes a text one symbol item at a time and, on the item marked last,
// emits the chosen vowels in order of choice, the final one flagged.
// A symbol that forms an unequal pair with the one before it also goes
// through S_INC for the read and write back of the pair-count memory;
// any other symbol does not. The run after the last symbol builds the row
// sums from the memory, then per vowel does a scan, one pick and an update
// pass, then a final scan, and finally a clearing pass over the pair-count
// memory. The same clearing pass runs after reset; no input item is taken
// during it, while configuration writes still are.
module sukhotin_vowel_finder_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  svf_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output svf_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [svf_pkg::MAXV_W-1:0]  cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INC   = 7'b0000010,
    S_ROWS  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_PICK  = 7'b0010000,
    S_SUB   = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_t;

  localparam logic [svf_pkg::SYM_W-1:0] LAST_SYM = svf_pkg::SYM_W'(svf_pkg::NUM_SYMBOLS - 1);
  localparam logic [svf_pkg::PC_AW-1:0] LAST_ADDR = svf_pkg::PC_AW'(svf_pkg::PC_DEPTH - 1);
  localparam logic [svf_pkg::CNT_W-1:0] CNT_MAX = '1;

  state_t state;
  logic   clearing;

  logic [svf_pkg::MAXV_W-1:0] max_vowels;
  logic [svf_pkg::SYM_W-1:0]  prev_sym;
  logic                       have_prev;
  logic [svf_pkg::SEEN_W-1:0] seen;
  logic                       dropped;
  logic                       run_pending;
  logic [svf_pkg::PC_AW-1:0]  inc_addr;
  logic [svf_pkg::PC_AW-1:0]  clr;

  logic [svf_pkg::SYM_W-1:0]  r, j, i;
  logic signed [svf_pkg::RS_W-1:0] best;
  logic [svf_pkg::SYM_W-1:0]  pick;
  logic                       any;
  logic [svf_pkg::NUM_SYMBOLS-1:0] mask;
  logic [svf_pkg::MAXV_W-1:0] count;
  logic [svf_pkg::SYM_W-1:0]  pend;
  logic                       pend_valid;

  // read-data tags, aligned with the registered memory output
  logic                       rd_row_v, rd_sub_v, rd_first, rd_lastj;
  logic [svf_pkg::SYM_W-1:0]  rd_idx;

  logic signed [svf_pkg::RS_W-1:0] rs [svf_pkg::NUM_SYMBOLS];
  logic [svf_pkg::RS_W-1:0]   acc;

  // pair-count memory
  logic [svf_pkg::CNT_W-1:0]  pc_mem [svf_pkg::PC_DEPTH];
  logic [svf_pkg::CNT_W-1:0]  mem_rdata;
  logic [svf_pkg::CNT_W-1:0]  mem_wdata;
  logic [svf_pkg::PC_AW-1:0]  mem_raddr, mem_waddr;
  logic                       mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pc_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= pc_mem[mem_raddr];
  end

  // handshake helpers
  logic in_acc, out_free, out_load, sym_ok, do_pair;
  svf_pkg::out_t out_next;
  logic [svf_pkg::MAXV_W-1:0] limit;

  assign in_ready = (state == S_IDLE) && !clearing;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign sym_ok   = in_data.symbol < svf_pkg::SYM_W'(svf_pkg::NUM_SYMBOLS);
  assign do_pair  = sym_ok && (seen < svf_pkg::SEEN_W'(svf_pkg::MAX_TEXT)) && have_prev &&
                    (prev_sym != in_data.symbol);
  assign limit    = (max_vowels > svf_pkg::MAXV_W'(svf_pkg::VOWEL_LIMIT)) ?
                    svf_pkg::MAXV_W'(svf_pkg::VOWEL_LIMIT) : max_vowels;

  // memory address and write selection
  always_comb begin
    mem_raddr = svf_pkg::pair_addr(prev_sym, in_data.symbol);
    mem_we    = 1'b0;
    mem_waddr = inc_addr;
    mem_wdata = mem_rdata + svf_pkg::CNT_W'(1);
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr;
      mem_wdata = '0;
    end else begin
      case (state)
        S_INC:   mem_we = (mem_rdata != CNT_MAX);
        S_ROWS:  mem_raddr = svf_pkg::pair_addr(r, j);
        S_SUB:   mem_raddr = svf_pkg::pair_addr(i, pick);
        default: mem_raddr = svf_pkg::pair_addr(prev_sym, in_data.symbol);
      endcase
    end
  end

  // result register loading
  always_comb begin
    out_load = 1'b0;
    out_next = '{vowel: pend, found: 1'b1, overflow: dropped, final_res: 1'b0};
    case (state)
      S_PICK:  out_load = pend_valid && out_free;
      S_FLUSH: begin
        out_load = out_free;
        out_next.final_res = 1'b1;
        if (!pend_valid) begin
          out_next.vowel = '0;
          out_next.found = 1'b0;
        end
      end
      default: out_load = 1'b0;
    endcase
  end

  // scan step: best positive row sum among unchosen symbols
  logic signed [svf_pkg::RS_W-1:0] best_n;
  logic [svf_pkg::SYM_W-1:0]  pick_n;
  logic                       any_n;
  always_comb begin
    best_n = best;
    pick_n = pick;
    any_n  = any;
    if (!mask[i] && (rs[i] > best)) begin
      best_n = rs[i];
      pick_n = i;
      any_n  = 1'b1;
    end
  end

  // row-sum build and update from memory read data
  logic [svf_pkg::RS_W-1:0] acc_n;
  logic signed [svf_pkg::RS_W-1:0] sub_val;
  assign acc_n   = rd_first ? svf_pkg::RS_W'(mem_rdata) : acc + svf_pkg::RS_W'(mem_rdata);
  assign sub_val = signed'({1'b0, mem_rdata, 1'b0});

  always_ff @(posedge clk) begin
    if (rd_row_v) begin
      acc <= acc_n;
      if (rd_lastj) begin
        rs[rd_idx] <= signed'(acc_n);
      end
    end
    if (rd_sub_v && !mask[rd_idx]) begin
      rs[rd_idx] <= rs[rd_idx] - sub_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_vowels <= svf_pkg::MAXV_W'(svf_pkg::VOWEL_LIMIT);
    end else if (cfg_we) begin
      max_vowels <= cfg_data;
    end
  end

  // clearing pass over the pair-count memory
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr      <= '0;
    end else if (clearing) begin
      if (clr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
      clr <= clr + svf_pkg::PC_AW'(1);
    end else if (state == S_FLUSH && out_free) begin
      clearing <= 1'b1;
      clr      <= '0;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      have_prev   <= 1'b0;
      seen        <= '0;
      dropped     <= 1'b0;
      pend_valid  <= 1'b0;
      run_pending <= 1'b0;
      rd_row_v    <= 1'b0;
      rd_sub_v    <= 1'b0;
      mask        <= '0;
      count       <= '0;
    end else begin
      rd_row_v <= 1'b0;
      rd_sub_v <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (sym_ok) begin
              if (seen >= svf_pkg::SEEN_W'(svf_pkg::MAX_TEXT)) begin
                dropped <= 1'b1;
              end else begin
                prev_sym  <= in_data.symbol;
                have_prev <= 1'b1;
                seen      <= seen + svf_pkg::SEEN_W'(1);
              end
            end
            run_pending <= in_data.last;
            if (do_pair) begin
              inc_addr <= mem_raddr;
              state    <= S_INC;
            end else if (in_data.last) begin
              state <= S_ROWS;
              r     <= '0;
              j     <= '0;
              mask  <= '0;
              count <= '0;
            end
          end
        end
        S_INC: begin
          if (run_pending) begin
            state <= S_ROWS;
            r     <= '0;
            j     <= '0;
            mask  <= '0;
            count <= '0;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ROWS: begin
          rd_row_v <= 1'b1;
          rd_idx   <= r;
          rd_first <= (j == '0);
          rd_lastj <= (j == LAST_SYM);
          if (j == LAST_SYM) begin
            j <= '0;
            if (r == LAST_SYM) begin
              state <= S_SCAN;
              i     <= '0;
              best  <= '0;
              any   <= 1'b0;
            end else begin
              r <= r + svf_pkg::SYM_W'(1);
            end
          end else begin
            j <= j + svf_pkg::SYM_W'(1);
          end
        end
        S_SCAN: begin
          best <= best_n;
          pick <= pick_n;
          any  <= any_n;
          if (i == LAST_SYM) begin
            if (!any_n || count >= limit) begin
              state <= S_FLUSH;
            end else begin
              state <= S_PICK;
            end
          end else begin
            i <= i + svf_pkg::SYM_W'(1);
          end
        end
        S_PICK: begin
          if (!pend_valid || out_free) begin
            pend        <= pick;
            pend_valid  <= 1'b1;
            mask[pick]  <= 1'b1;
            count       <= count + svf_pkg::MAXV_W'(1);
            i           <= '0;
            state       <= S_SUB;
          end
        end
        S_SUB: begin
          rd_sub_v <= 1'b1;
          rd_idx   <= i;
          if (i == LAST_SYM) begin
            state <= S_SCAN;
            i     <= '0;
            best  <= '0;
            any   <= 1'b0;
          end else begin
            i <= i + svf_pkg::SYM_W'(1);
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            pend_valid  <= 1'b0;
            have_prev   <= 1'b0;
            seen        <= '0;
            dropped     <= 1'b0;
            run_pending <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
